[rtl/drt_pkg.sv]
// drt_pkg: shared constants, stage bus types and compact target expansion
// used by every file of the difficulty retarget block but drt_checker; no dependencies
package drt_pkg;

    localparam int unsigned WideW = 256;

    localparam logic [30:0] HistoryHeight = 31'd15000;
    localparam logic [15:0] SpanMin       = 16'd2700;
    localparam logic [15:0] SpanMax       = 16'd43200;
    localparam logic [13:0] TargetSpan    = 14'd10800;   // 3 * 60 * 60
    localparam logic [31:0] LimitReset    = 32'h1e0fffff;

    // floor(x / 10800) == (x * DivRecip) >> DivShift for any x below 2^30
    localparam logic [30:0] DivRecip = 31'd1628906116;
    localparam int unsigned DivShift = 44;

    localparam int unsigned MulCells = WideW / 32;
    localparam int unsigned DivCells = WideW / 16;

    typedef struct packed {
        logic             valid;
        logic [WideW-1:0] value;
        logic [15:0]      span;
        logic [15:0]      carry;
    } t_mul_bus;

    typedef struct packed {
        logic             valid;
        logic [WideW-1:0] value;
        logic [13:0]      rem;
    } t_div_bus;

    typedef struct packed {
        logic             valid;
        logic [WideW-1:0] value;
        logic [29:0]      cur;
        logic [15:0]      quo;
    } t_div_mid;

    // compact word to 256-bit integer; sign bit ignored, oversize shifts give zero
    function automatic logic [WideW-1:0] expand_compact(input logic [31:0] bits);
        logic [7:0]       expo;
        logic [22:0]      mant;
        logic [7:0]       sh;
        logic [WideW-1:0] v;
        expo = bits[31:24];
        mant = bits[22:0];
        sh   = expo - 8'd3;
        v    = '0;
        if (expo <= 8'd3) begin
            unique case (expo[1:0])
                2'd0: v = '0;
                2'd1: v = {{(WideW-7){1'b0}}, mant[22:16]};
                2'd2: v = {{(WideW-15){1'b0}}, mant[22:8]};
                default: v = {{(WideW-23){1'b0}}, mant};
            endcase
        end else if (sh < 8'd32) begin
            v = {{(WideW-23){1'b0}}, mant} << {sh[4:0], 3'b000};
        end
        return v;
    endfunction

endpackage

[rtl/drt_mul_cell.sv]
// drt_mul_cell: one 32-bit limb of the target times span step
// depends on drt_pkg; the value rotates one limb down per cell
module drt_mul_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  drt_pkg::t_mul_bus i_bus,
    output drt_pkg::t_mul_bus o_bus
);
    import drt_pkg::*;

    t_mul_bus    r_bus;
    t_mul_bus    n_bus;
    logic [47:0] prod;

    assign prod = 48'(i_bus.value[31:0]) * 48'(i_bus.span) + 48'(i_bus.carry);

    always_comb begin
        n_bus       = i_bus;
        // finished limb goes in at the top, the next one comes down to bit 0
        n_bus.value = {prod[31:0], i_bus.value[WideW-1:32]};
        n_bus.carry = prod[47:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

[rtl/drt_div_cell.sv]
// drt_div_cell: one 16-bit digit of the divide by 10800, two register stages
// depends on drt_pkg; quotient digit by reciprocal, then the remainder
module drt_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  drt_pkg::t_div_bus i_bus,
    output drt_pkg::t_div_bus o_bus
);
    import drt_pkg::*;

    t_div_mid    r_mid;
    t_div_mid    n_mid;
    t_div_bus    r_bus;
    t_div_bus    n_bus;
    logic [60:0] recip_prod;
    logic [29:0] back_prod;
    logic [29:0] rem_full;

    always_comb begin
        n_mid.valid = i_bus.valid;
        n_mid.value = i_bus.value;
        n_mid.cur   = {i_bus.rem, i_bus.value[WideW-1:WideW-16]};
        recip_prod  = 61'(n_mid.cur) * 61'(DivRecip);
        n_mid.quo   = recip_prod[DivShift +: 16];
    end

    always_comb begin
        back_prod   = 30'(r_mid.quo) * 30'(TargetSpan);
        rem_full    = r_mid.cur - back_prod;
        n_bus.valid = r_mid.valid;
        // quotient digit enters at the bottom as the dividend shifts up
        n_bus.value = {r_mid.value[WideW-17:0], r_mid.quo};
        n_bus.rem   = rem_full[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_mid <= n_mid;
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

[rtl/drt_encode.sv]
// drt_encode: cap at the limit and re-encode to compact form, four stages
// depends on drt_pkg; last stage is the result register
module drt_encode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  drt_pkg::t_div_bus         i_bus,
    input  logic [drt_pkg::WideW-1:0] i_limit,
    output logic                      o_valid,
    output logic [31:0]               o_bits
);
    import drt_pkg::*;

    logic             r_e1_valid;
    logic [WideW-1:0] r_e1_value;
    logic [7:0]       r_e1_gt;
    logic [7:0]       r_e1_eq;
    logic [7:0]       n_e1_gt;
    logic [7:0]       n_e1_eq;

    logic             r_e2_valid;
    logic [WideW-1:0] r_e2_sel;
    logic             greater;

    logic             r_e3_valid;
    logic [WideW-1:0] r_e3_sel;
    logic [5:0]       r_e3_size;
    logic [5:0]       n_e3_size;
    logic [7:0]       limb_nz;
    logic [1:0]       limb_hb [8];

    logic             r_out_valid;
    logic [31:0]      r_out_bits;
    logic [31:0]      n_out_bits;
    logic [23:0]      word;

    function automatic logic [7:0] byte_at(input logic [WideW-1:0] v,
                                           input logic [5:0] size,
                                           input logic [1:0] below);
        logic signed [6:0] idx;
        idx = $signed({1'b0, size}) - $signed({5'b0, below}) - 7'sd1;
        if (idx < 0) begin
            return 8'h00;
        end
        return v[{idx[4:0], 3'b000} +: 8];
    endfunction

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_e1_gt[i] = i_bus.value[32*i +: 32] > i_limit[32*i +: 32];
            n_e1_eq[i] = i_bus.value[32*i +: 32] == i_limit[32*i +: 32];
        end
    end

    // top limb that differs decides
    always_comb begin
        greater = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (r_e1_gt[i]) begin
                greater = 1'b1;
            end else if (!r_e1_eq[i]) begin
                greater = 1'b0;
            end
        end
    end

    always_comb begin
        n_e3_size = '0;
        for (int i = 0; i < 8; i++) begin
            limb_nz[i] = |r_e2_sel[32*i +: 32];
            limb_hb[i] = 2'd0;
            for (int b = 0; b < 4; b++) begin
                if (|r_e2_sel[32*i + 8*b +: 8]) begin
                    limb_hb[i] = 2'(b);
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            if (limb_nz[i]) begin
                n_e3_size = {1'b0, 3'(i), limb_hb[i]} + 6'd1;
            end
        end
    end

    always_comb begin
        word = {byte_at(r_e3_sel, r_e3_size, 2'd0),
                byte_at(r_e3_sel, r_e3_size, 2'd1),
                byte_at(r_e3_sel, r_e3_size, 2'd2)};
        // mantissa may not carry the sign bit: move down a byte
        if (word[23]) begin
            n_out_bits = {2'b00, r_e3_size + 6'd1, 8'h00, word[23:8]};
        end else begin
            n_out_bits = {2'b00, r_e3_size, word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid  <= 1'b0;
            r_e2_valid  <= 1'b0;
            r_e3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_e1_valid  <= i_bus.valid;
            r_e1_value  <= i_bus.value;
            r_e1_gt     <= n_e1_gt;
            r_e1_eq     <= n_e1_eq;
            r_e2_valid  <= r_e1_valid;
            r_e2_sel    <= greater ? i_limit : r_e1_value;
            r_e3_valid  <= r_e2_valid;
            r_e3_sel    <= r_e2_sel;
            r_e3_size   <= n_e3_size;
            r_out_valid <= r_e3_valid;
            r_out_bits  <= n_out_bits;
        end
    end

    assign o_valid = r_out_valid;
    assign o_bits  = r_out_bits;

endmodule

[rtl/difficulty_retarget_top.sv]
// difficulty_retarget_top: next compact target after a retarget window.
// pipeline: an accepted request passes the input stage, 8 multiply cells,
// 16 two-stage divide cells and 4 encode stages before its result is shown.
// throughput: one request per cycle; the whole chain holds only while a
// result sits in the output register and the output is stalled.
// reset: synchronous active low, empties the chain and restores the limit.
module difficulty_retarget_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [30:0] i_in_last_height,
    input  logic [31:0] i_in_last_time,
    input  logic [31:0] i_in_first_time,
    input  logic [31:0] i_in_last_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_out_next_bits,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    import drt_pkg::*;

    logic             en;
    logic [31:0]      r_limit_bits;
    logic [WideW-1:0] r_limit_wide;
    t_mul_bus         r_s0;
    t_mul_bus         n_s0;
    logic [32:0]      diff;
    logic [31:0]      mag;
    t_mul_bus         mul_bus [MulCells+1];
    t_div_bus         div_bus [DivCells+1];

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_comb begin
        diff = {1'b0, i_in_last_time} - {1'b0, i_in_first_time};
        // quarter span past the history height; negatives clamp low anyway
        mag  = (i_in_last_height > HistoryHeight) ? {2'b00, diff[31:2]} : diff[31:0];
        n_s0.valid = i_in_valid;
        n_s0.value = expand_compact(i_in_last_bits);
        n_s0.carry = '0;
        if (diff[32] || mag < {16'b0, SpanMin}) begin
            n_s0.span = SpanMin;
        end else if (mag > {16'b0, SpanMax}) begin
            n_s0.span = SpanMax;
        end else begin
            n_s0.span = mag[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_bits <= LimitReset;
            r_s0.valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit_bits <= i_cfg_data;
            end
            if (en) begin
                r_s0 <= n_s0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit_wide <= expand_compact(r_limit_bits);
    end

    assign mul_bus[0] = r_s0;

    for (genvar g = 0; g < MulCells; g++) begin : g_mul
        drt_mul_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (mul_bus[g]),
            .o_bus   (mul_bus[g+1])
        );
    end

    assign div_bus[0].valid = mul_bus[MulCells].valid;
    assign div_bus[0].value = mul_bus[MulCells].value;
    assign div_bus[0].rem   = '0;

    for (genvar g = 0; g < DivCells; g++) begin : g_div
        drt_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (div_bus[g]),
            .o_bus   (div_bus[g+1])
        );
    end

    drt_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_bus   (div_bus[DivCells]),
        .i_limit (r_limit_wide),
        .o_valid (o_out_valid),
        .o_bits  (o_out_next_bits)
    );

endmodule

[rtl/drt_checker.sv]
// drt_checker: port-level assertions for difficulty_retarget_top
// depends only on the top level's ports; bound in below
module drt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_out_next_bits
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_next_bits))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_mant_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_next_bits[23])
        else $error("mantissa sign bit set");

    a_expo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_next_bits[31:24] <= 8'd33)
        else $error("exponent out of range");

endmodule

bind difficulty_retarget_top drt_checker u_drt_checker (.*);
